@@ hw/rtl/slcd_pkg.sv @@
// ----------------------------------------------------------------------------
// slcd_pkg
// Shared types and constants of the serial character LCD text buffer driver.
// ----------------------------------------------------------------------------
package slcd_pkg;

   localparam int DISPLAYS       = 2;
   localparam int BUFFER_DEPTH   = 128;
   localparam int STORE_DEPTH    = DISPLAYS * BUFFER_DEPTH;
   localparam int POS_W          = $clog2(BUFFER_DEPTH);
   localparam int DISP_W         = (DISPLAYS > 1) ? $clog2(DISPLAYS) : 1;
   localparam int ADDR_W         = $clog2(STORE_DEPTH);
   localparam int CHARS_PER_PART = 4;
   localparam int PIN_LANES      = 2;
   localparam int LINE_LEN       = 16;

   localparam int CSR_COUNT = 2;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DW    = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_DISPLAY_ADDR_0 = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_DISPLAY_ADDR_1 = 1'b1;

   localparam logic REQ_TICK  = 1'b0;
   localparam logic REQ_WRITE = 1'b1;

   localparam logic [7:0] GOTO_BASE  = 8'h80;
   localparam logic [7:0] CMD_HOME   = 8'h02;
   localparam logic [7:0] CMD_CLEAR  = 8'h01;
   localparam logic [7:0] PART0_MODE = 8'hFE;
   localparam logic [7:0] LINE_MARK  = 8'h7C;
   localparam logic [3:0] HOME_CODE  = 4'd1;

   typedef enum logic [1:0] {
      ST_TICK,
      ST_WRITTEN,
      ST_BUSY,
      ST_NO_MATCH
   } status_type;

   typedef enum logic [2:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_WRITE,
      BK_TICK_RD,
      BK_TICK_SHIFT,
      BK_TICK_NEXT,
      BK_DONE
   } back_state_type;

   // one store entry: flag is RS (1 data, 0 command)
   typedef struct packed {
      logic       flag;
      logic [7:0] data;
   } entry_type;

   // classified word handed from front to back
   typedef struct packed {
      logic                               is_tick;
      logic [DISPLAYS-1:0]                match;
      logic [3:0]                         part;
      logic                               home;
      logic                               start;
      entry_type [CHARS_PER_PART-1:0]     chars;
   } item_type;

   // goto-line command for the character at slot k of a part
   function automatic logic [7:0] goto_code(logic [3:0] part, logic [1:0] k);
      logic [5:0] idx;
      logic [7:0] line;
      idx  = {part, k};
      line = 8'(idx / LINE_LEN) + 8'd1;
      return GOTO_BASE + 8'(line * 8'(LINE_LEN));
   endfunction

endpackage

@@ hw/rtl/slcd_front.sv @@
// ----------------------------------------------------------------------------
// slcd_front
// Address registers, request decode and a two-word command queue.
// ----------------------------------------------------------------------------
module slcd_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_push,
   output logic                         req_full,
   input  logic                         req_cmd,
   input  logic [15:0]                  req_target_addr,
   input  logic [3:0]                   req_part,
   input  logic [3:0]                   req_start_code,
   input  logic [7:0]                   req_char_a,
   input  logic [7:0]                   req_char_b,
   input  logic [7:0]                   req_char_c,
   input  logic [7:0]                   req_char_d,
   input  logic                         csr_we,
   input  logic [slcd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [slcd_pkg::CSR_DW-1:0]  csr_wdata,
   input  logic                         hold,
   output slcd_pkg::item_type           head_item,
   output logic                         head_valid,
   input  logic                         head_pop
);
   import slcd_pkg::*;

   localparam int Q_DEPTH = 2;
   localparam int QP_W    = $clog2(Q_DEPTH);
   localparam int QC_W    = $clog2(Q_DEPTH + 1);

   logic [CSR_DW-1:0] disp_addr_ff [CSR_COUNT];
   item_type          q_ff [Q_DEPTH];
   logic [QP_W-1:0]   q_wr_ff, q_wr_in;
   logic [QP_W-1:0]   q_rd_ff, q_rd_in;
   logic [QC_W-1:0]   q_cnt_ff, q_cnt_in;
   item_type          dec;
   logic [7:0]        raw [CHARS_PER_PART];
   logic              push_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         disp_addr_ff[CSR_DISPLAY_ADDR_0] <= '0;
         disp_addr_ff[CSR_DISPLAY_ADDR_1] <= '0;
      end else if (csr_we) begin
         disp_addr_ff[csr_index] <= csr_wdata;
      end
   end

   always_comb begin
      raw[0] = req_char_a;
      raw[1] = req_char_b;
      raw[2] = req_char_c;
      raw[3] = req_char_d;
      dec         = '0;
      dec.is_tick = (req_cmd == REQ_TICK);
      dec.part    = req_part;
      dec.home    = (req_start_code == HOME_CODE);
      for (int d = 0; d < DISPLAYS; d++) begin
         dec.match[d] = (disp_addr_ff[d] == req_target_addr);
      end
      for (int k = 0; k < CHARS_PER_PART; k++) begin
         if (raw[k] == LINE_MARK) begin
            dec.chars[k].flag = 1'b0;
            dec.chars[k].data = goto_code(req_part, 2'(k));
         end else begin
            dec.chars[k].flag = 1'b1;
            dec.chars[k].data = raw[k];
         end
         if (raw[k] == 8'd0) begin
            dec.start = 1'b1;
         end
      end
   end

   assign req_full   = (q_cnt_ff == QC_W'(Q_DEPTH)) || hold;
   assign push_ok    = req_push && !req_full;
   assign head_valid = (q_cnt_ff != '0);
   assign head_item  = q_ff[q_rd_ff];

   always_comb begin
      q_wr_in  = push_ok ? q_wr_ff + QP_W'(1) : q_wr_ff;
      q_rd_in  = head_pop ? q_rd_ff + QP_W'(1) : q_rd_ff;
      q_cnt_in = q_cnt_ff + QC_W'(push_ok) - QC_W'(head_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_wr_ff  <= '0;
         q_rd_ff  <= '0;
         q_cnt_ff <= '0;
      end else begin
         q_wr_ff  <= q_wr_in;
         q_rd_ff  <= q_rd_in;
         q_cnt_ff <= q_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         q_ff[q_wr_ff] <= dec;
      end
   end

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      q_cnt_ff <= QC_W'(Q_DEPTH))
      else $error("command queue count out of range");

   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      head_pop |-> head_valid)
      else $error("pop from empty command queue");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push_ok |-> (q_cnt_ff != QC_W'(Q_DEPTH)))
      else $error("push into full command queue");

endmodule

@@ hw/rtl/slcd_back.sv @@
// ----------------------------------------------------------------------------
// slcd_back
// Text store, write sequencer, serial shifter and result register.
// ----------------------------------------------------------------------------
module slcd_back (
   input  logic                             clock,
   input  logic                             reset,
   input  slcd_pkg::item_type               head_item,
   input  logic                             head_valid,
   output logic                             head_pop,
   output logic                             clearing,
   input  logic                             rsp_pop,
   output logic                             rsp_empty,
   output logic [1:0]                       rsp_status,
   output logic                             rsp_clk_level,
   output logic [slcd_pkg::PIN_LANES-1:0]   rsp_cs_n,
   output logic [slcd_pkg::PIN_LANES-1:0]   rsp_rs,
   output logic [slcd_pkg::PIN_LANES-1:0]   rsp_si,
   output logic [slcd_pkg::PIN_LANES-1:0]   rsp_sending
);
   import slcd_pkg::*;

   localparam logic [2:0] STEP_CMD        = 3'd0;
   localparam logic [2:0] STEP_CHAR_FIRST = 3'd4;
   localparam logic [2:0] STEP_LAST       = 3'd7;
   localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(STORE_DEPTH - 1);
   localparam logic [DISP_W-1:0] DISP_LAST = DISP_W'(DISPLAYS - 1);

   back_state_type      state_ff, state_in;
   item_type            cur_ff, cur_in;
   logic [DISP_W-1:0]   disp_ff, disp_in;
   logic [2:0]          step_ff, step_in;
   logic [ADDR_W-1:0]   clr_ff, clr_in;
   status_type          status_ff, status_in;
   logic                phase_ff, phase_in;
   logic [DISPLAYS-1:0] pending_ff, pending_in;
   logic [DISPLAYS-1:0] cs_ff, cs_in;
   logic [DISPLAYS-1:0] rs_ff, rs_in;
   logic [DISPLAYS-1:0] si_ff, si_in;
   logic [POS_W-1:0]    byte_pos_ff [DISPLAYS];
   logic [POS_W-1:0]    byte_pos_in [DISPLAYS];
   logic [2:0]          bit_pos_ff [DISPLAYS];
   logic [2:0]          bit_pos_in [DISPLAYS];

   logic                out_valid_ff, out_valid_in;
   status_type          out_status_ff;
   logic                out_level_ff;
   logic [PIN_LANES-1:0] out_cs_ff, out_rs_ff, out_si_ff, out_snd_ff;
   logic [PIN_LANES-1:0] cs_lanes, rs_lanes, si_lanes, snd_lanes;
   logic                load_out;

   logic [7:0]          byte_mem [STORE_DEPTH];
   logic                flag_mem [STORE_DEPTH];
   logic [7:0]          byte_rd_ff;
   logic                flag_rd_ff;
   logic                byte_we, flag_we, rd_en;
   logic [ADDR_W-1:0]   wr_addr, rd_addr;
   logic [7:0]          wr_byte;
   logic                wr_flag;

   logic [POS_W-1:0]    cur_pos;
   logic [2:0]          cur_bit;
   logic [POS_W:0]      next_pos;
   logic                last_disp;

   function automatic logic [ADDR_W-1:0] store_addr(logic [DISP_W-1:0] d,
                                                    logic [POS_W-1:0] p);
      return ADDR_W'(ADDR_W'(d) * ADDR_W'(BUFFER_DEPTH)) + ADDR_W'(p);
   endfunction

   assign cur_pos   = byte_pos_ff[disp_ff];
   assign cur_bit   = bit_pos_ff[disp_ff];
   assign next_pos  = {1'b0, cur_pos} + (POS_W+1)'(1);
   assign last_disp = (disp_ff == DISP_LAST);
   assign clearing  = (state_ff == BK_CLEAR);

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      disp_in      = disp_ff;
      step_in      = step_ff;
      clr_in       = clr_ff;
      status_in    = status_ff;
      phase_in     = phase_ff;
      pending_in   = pending_ff;
      cs_in        = cs_ff;
      rs_in        = rs_ff;
      si_in        = si_ff;
      byte_pos_in  = byte_pos_ff;
      bit_pos_in   = bit_pos_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      load_out     = 1'b0;
      head_pop     = 1'b0;
      byte_we      = 1'b0;
      flag_we      = 1'b0;
      wr_addr      = '0;
      wr_byte      = '0;
      wr_flag      = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = '0;

      unique case (state_ff)
         BK_CLEAR: begin
            byte_we = 1'b1;
            flag_we = 1'b1;
            wr_addr = clr_ff;
            clr_in  = clr_ff + ADDR_W'(1);
            if (clr_ff == CLR_LAST) begin
               state_in = BK_IDLE;
            end
         end

         BK_IDLE: begin
            if (head_valid) begin
               head_pop = 1'b1;
               cur_in   = head_item;
               disp_in  = '0;
               if (head_item.is_tick) begin
                  phase_in  = !phase_ff;
                  status_in = ST_TICK;
                  // shifting happens on the falling phase only
                  state_in  = phase_ff ? BK_TICK_RD : BK_DONE;
               end else if (head_item.match == '0) begin
                  status_in = ST_NO_MATCH;
                  state_in  = BK_DONE;
               end else if ((head_item.match & pending_ff) != '0) begin
                  status_in = ST_BUSY;
                  state_in  = BK_DONE;
               end else begin
                  status_in = ST_WRITTEN;
                  step_in   = (head_item.part == 4'd0) ? STEP_CMD : STEP_CHAR_FIRST;
                  state_in  = BK_WRITE;
               end
            end
         end

         BK_WRITE: begin
            if (cur_ff.match[disp_ff]) begin
               if (step_ff == STEP_CMD) begin
                  byte_we = 1'b1;
                  flag_we = 1'b1;
                  wr_addr = store_addr(disp_ff, '0);
                  wr_byte = cur_ff.home ? CMD_HOME : CMD_CLEAR;
               end else if (step_ff < STEP_CHAR_FIRST) begin
                  // part 0 tags the tail of the first eight entries as data
                  flag_we = PART0_MODE[3'(step_ff + 3'(CHARS_PER_PART))];
                  wr_addr = store_addr(disp_ff,
                                       POS_W'(step_ff) + POS_W'(CHARS_PER_PART));
                  wr_flag = 1'b1;
               end else begin
                  byte_we = 1'b1;
                  flag_we = 1'b1;
                  wr_addr = store_addr(disp_ff,
                                       POS_W'({cur_ff.part, step_ff[1:0]}) + POS_W'(1));
                  wr_byte = cur_ff.chars[step_ff[1:0]].data;
                  wr_flag = cur_ff.chars[step_ff[1:0]].flag;
               end
               step_in = step_ff + 3'd1;
            end
            if (!cur_ff.match[disp_ff] || step_ff == STEP_LAST) begin
               if (cur_ff.match[disp_ff] && cur_ff.start) begin
                  pending_in[disp_ff]  = 1'b1;
                  byte_pos_in[disp_ff] = '0;
                  bit_pos_in[disp_ff]  = '0;
               end
               step_in = (cur_ff.part == 4'd0) ? STEP_CMD : STEP_CHAR_FIRST;
               if (last_disp) begin
                  state_in = BK_DONE;
               end else begin
                  disp_in = disp_ff + DISP_W'(1);
               end
            end
         end

         BK_TICK_RD: begin
            if (pending_ff[disp_ff]) begin
               rd_en    = 1'b1;
               rd_addr  = store_addr(disp_ff, cur_pos);
               state_in = BK_TICK_SHIFT;
            end else begin
               cs_in[disp_ff] = 1'b1;
               if (last_disp) begin
                  state_in = BK_DONE;
               end else begin
                  disp_in = disp_ff + DISP_W'(1);
               end
            end
         end

         BK_TICK_SHIFT: begin
            cs_in[disp_ff] = 1'b0;
            rs_in[disp_ff] = flag_rd_ff;
            si_in[disp_ff] = byte_rd_ff[~cur_bit];
            state_in       = last_disp ? BK_DONE : BK_TICK_RD;
            disp_in        = last_disp ? disp_ff : disp_ff + DISP_W'(1);
            if (cur_bit == 3'd7) begin
               bit_pos_in[disp_ff] = '0;
               if (next_pos >= (POS_W+1)'(BUFFER_DEPTH)) begin
                  byte_pos_in[disp_ff] = '0;
                  pending_in[disp_ff]  = 1'b0;
               end else begin
                  // look ahead at the next byte to see if the text ends
                  rd_en    = 1'b1;
                  rd_addr  = store_addr(disp_ff, next_pos[POS_W-1:0]);
                  state_in = BK_TICK_NEXT;
                  disp_in  = disp_ff;
               end
            end else begin
               bit_pos_in[disp_ff] = cur_bit + 3'd1;
            end
         end

         BK_TICK_NEXT: begin
            if (byte_rd_ff == 8'd0) begin
               byte_pos_in[disp_ff] = '0;
               pending_in[disp_ff]  = 1'b0;
            end else begin
               byte_pos_in[disp_ff] = next_pos[POS_W-1:0];
            end
            if (last_disp) begin
               state_in = BK_DONE;
            end else begin
               disp_in  = disp_ff + DISP_W'(1);
               state_in = BK_TICK_RD;
            end
         end

         BK_DONE: begin
            if (!out_valid_ff || rsp_pop) begin
               out_valid_in = 1'b1;
               load_out     = 1'b1;
               state_in     = BK_IDLE;
            end
         end

         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_CLEAR;
         disp_ff      <= '0;
         step_ff      <= STEP_CMD;
         clr_ff       <= '0;
         status_ff    <= ST_TICK;
         phase_ff     <= 1'b0;
         pending_ff   <= '0;
         cs_ff        <= '1;
         rs_ff        <= '0;
         si_ff        <= '0;
         out_valid_ff <= 1'b0;
         for (int d = 0; d < DISPLAYS; d++) begin
            byte_pos_ff[d] <= '0;
            bit_pos_ff[d]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         disp_ff      <= disp_in;
         step_ff      <= step_in;
         clr_ff       <= clr_in;
         status_ff    <= status_in;
         phase_ff     <= phase_in;
         pending_ff   <= pending_in;
         cs_ff        <= cs_in;
         rs_ff        <= rs_in;
         si_ff        <= si_in;
         out_valid_ff <= out_valid_in;
         byte_pos_ff  <= byte_pos_in;
         bit_pos_ff   <= bit_pos_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   // text store: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (byte_we) begin
         byte_mem[wr_addr] <= wr_byte;
      end
      if (flag_we) begin
         flag_mem[wr_addr] <= wr_flag;
      end
      if (rd_en) begin
         byte_rd_ff <= byte_mem[rd_addr];
         flag_rd_ff <= flag_mem[rd_addr];
      end
   end

   // absent displays read as deselected and idle
   always_comb begin
      cs_lanes  = '1;
      rs_lanes  = '0;
      si_lanes  = '0;
      snd_lanes = '0;
      for (int d = 0; d < DISPLAYS; d++) begin
         cs_lanes[d]  = cs_ff[d];
         rs_lanes[d]  = rs_ff[d];
         si_lanes[d]  = si_ff[d];
         snd_lanes[d] = pending_ff[d];
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         out_status_ff <= status_ff;
         out_level_ff  <= phase_ff;
         out_cs_ff     <= ~cs_lanes ^ '1;
         out_rs_ff     <= rs_lanes;
         out_si_ff     <= si_lanes;
         out_snd_ff    <= snd_lanes;
      end
   end

   assign rsp_empty     = !out_valid_ff;
   assign rsp_status    = out_status_ff;
   assign rsp_clk_level = out_level_ff;
   assign rsp_cs_n      = out_cs_ff;
   assign rsp_rs        = out_rs_ff;
   assign rsp_si        = out_si_ff;
   assign rsp_sending   = out_snd_ff;

   a_busy_pending: assert property (@(posedge clock) disable iff (reset)
      (load_out && status_ff == ST_BUSY) |-> (pending_ff != '0))
      else $error("busy status without a sending display");

   a_tick_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_TICK_RD || state_ff == BK_TICK_SHIFT ||
       state_ff == BK_TICK_NEXT) |-> (!byte_we && !flag_we))
      else $error("store written while shifting");

   for (genvar g = 0; g < DISPLAYS; g++) begin : g_pos_chk
      a_idle_pos: assert property (@(posedge clock) disable iff (reset)
         !pending_ff[g] |-> (byte_pos_ff[g] == '0))
         else $error("idle display left a nonzero byte position");
   end

endmodule

@@ hw/rtl/serial_lcd_text_buffer_driver.sv @@
// A rising-phase tick and a refused or unmatched write go straight to the result;
// a falling-phase tick shifts a bit per pending display; a write stores the four
// characters per matching display (part 0 also writes the command and data tags),
// one store entry per cycle. Throughput: one word at a time holds the sequencer
// until its result is loaded; two words can queue ahead. Reset is synchronous; the
// store is then cleared one entry per cycle, req_full high; address writes are taken.
// ----------------------------------------------------------------------------
// serial_lcd_text_buffer_driver
// Two-display serial character LCD driver with per-display text store.
// ----------------------------------------------------------------------------
module serial_lcd_text_buffer_driver (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_push,
   output logic                             req_full,
   input  logic                             req_cmd,
   input  logic [15:0]                      req_target_addr,
   input  logic [3:0]                       req_part,
   input  logic [3:0]                       req_start_code,
   input  logic [7:0]                       req_char_a,
   input  logic [7:0]                       req_char_b,
   input  logic [7:0]                       req_char_c,
   input  logic [7:0]                       req_char_d,
   output logic                             rsp_empty,
   input  logic                             rsp_pop,
   output logic [1:0]                       rsp_status,
   output logic                             rsp_clk_level,
   output logic [slcd_pkg::PIN_LANES-1:0]   rsp_cs_n,
   output logic [slcd_pkg::PIN_LANES-1:0]   rsp_rs,
   output logic [slcd_pkg::PIN_LANES-1:0]   rsp_si,
   output logic [slcd_pkg::PIN_LANES-1:0]   rsp_sending,
   input  logic                             csr_we,
   input  logic [slcd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [slcd_pkg::CSR_DW-1:0]      csr_wdata
);
   import slcd_pkg::*;

   item_type head_item;
   logic     head_valid;
   logic     head_pop;
   logic     clearing;

   slcd_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_cmd         (req_cmd),
      .req_target_addr (req_target_addr),
      .req_part        (req_part),
      .req_start_code  (req_start_code),
      .req_char_a      (req_char_a),
      .req_char_b      (req_char_b),
      .req_char_c      (req_char_c),
      .req_char_d      (req_char_d),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .hold            (clearing),
      .head_item       (head_item),
      .head_valid      (head_valid),
      .head_pop        (head_pop)
   );

   slcd_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_item     (head_item),
      .head_valid    (head_valid),
      .head_pop      (head_pop),
      .clearing      (clearing),
      .rsp_pop       (rsp_pop),
      .rsp_empty     (rsp_empty),
      .rsp_status    (rsp_status),
      .rsp_clk_level (rsp_clk_level),
      .rsp_cs_n      (rsp_cs_n),
      .rsp_rs        (rsp_rs),
      .rsp_si        (rsp_si),
      .rsp_sending   (rsp_sending)
   );

endmodule
